// ===== rtl/bitmap_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BBAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap block allocator check failed");

// Next-cycle implication, disabled while reset is held.
`define BBAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap block allocator check failed");

`endif

// ===== rtl/bbal_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Widths, codes and item types shared by the allocator modules.
// ----------------------------------------------------------------------------
package bbal_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int BLK_W      = 6;
  localparam int CNT_W      = 7;
  localparam int BYTES_W    = 22;
  localparam int BPB_W      = 16;
  localparam int NEED_W     = BYTES_W + 1;
  localparam int DIV_STEPS  = BYTES_W;
  localparam int DSTEP_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BPB_W;

  // Request modes.
  localparam logic [1:0] MODE_ALLOC_BYTES = 2'd0;
  localparam logic [1:0] MODE_ALLOC_ONE   = 2'd1;
  localparam logic [1:0] MODE_FREE        = 2'd2;
  localparam logic [1:0] MODE_UNUSED      = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE   = 1'd1;

  localparam logic [BPB_W-1:0] BPB_RESET = 16'd1024;
  localparam logic [CNT_W-1:0] BIU_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]         mode;
    logic [BYTES_W-1:0] byte_count;
    logic [BLK_W-1:0]   block_number_in;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    logic             last;
    logic [1:0]       status;
    logic [CNT_W-1:0] free_blocks;
  } out_item_t;

  typedef struct packed {
    logic [BPB_W-1:0] bytes_per_block;
    logic [CNT_W-1:0] blocks_in_use;
  } cfg_t;

endpackage

// ===== rtl/bbal_div.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator divider
// Restoring divider, one quotient bit per cycle, for file size over block size.
// ----------------------------------------------------------------------------
module bbal_div import bbal_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [BYTES_W-1:0] dividend,
  input  logic [BPB_W-1:0]   divisor,
  output logic               done,
  output logic [BYTES_W-1:0] quotient
);

  logic               busy_r;
  logic [DSTEP_W-1:0] step_r;
  logic [BPB_W-1:0]   rem_r;
  logic [BPB_W-1:0]   rem_nxt;
  logic [BPB_W-1:0]   dvs_r;
  logic [BYTES_W-1:0] quo_r;
  logic [BYTES_W-1:0] quo_nxt;
  logic [BPB_W:0]     trial;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, quo_r[BYTES_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? BPB_W'(trial - {1'b0, dvs_r}) : trial[BPB_W-1:0];
    quo_nxt = {quo_r[BYTES_W-2:0], fits};
  end

  assign done     = busy_r && (step_r == DSTEP_W'(DIV_STEPS - 1));
  assign quotient = quo_nxt;

  // Step counter and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= (divisor == '0) ? BPB_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r + DSTEP_W'(1);
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/bbal_seq.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator sequencer
// Occupancy map, free count and the scan, check and recount sequencer.
// ----------------------------------------------------------------------------
module bbal_seq import bbal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      recount_req,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_free,
  output logic      emit,
  output out_item_t res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECOUNT,
    S_DIV_WAIT,
    S_CHECK,
    S_SCAN,
    S_FREE
  } state_t;

  state_t              state_r;
  logic [NUM_BLOCKS-1:0] map_r;
  logic [CNT_W-1:0]    free_cnt_r;
  logic [CNT_W-1:0]    acc_r;
  logic [BLK_W-1:0]    idx_r;
  logic [NEED_W-1:0]   needed_r;
  logic [CNT_W-1:0]    rem_r;

  logic               div_start;
  logic               div_done;
  logic [BYTES_W-1:0] div_quo;
  logic [CNT_W-1:0]   area;
  logic               cur_taken;
  logic               in_area;
  logic               no_space;
  logic [CNT_W-1:0]   acc_inc;

  // Managed area, clipped to the map size.
  assign area      = (cfg.blocks_in_use > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                              : cfg.blocks_in_use;
  assign cur_taken = map_r[idx_r];
  assign in_area   = {1'b0, idx_r} < area;
  assign no_space  = needed_r > NEED_W'(free_cnt_r);
  assign acc_inc   = (in_area && !cur_taken) ? CNT_W'(1) : CNT_W'(0);

  assign in_ready  = (state_r == S_IDLE) && !recount_req;
  assign div_start = in_ready && in_valid && (in_item.mode == MODE_ALLOC_BYTES);

  bbal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_item.byte_count),
    .divisor  (cfg.bytes_per_block),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Result item for the current state, offered when the output slot is free.
  always_comb begin
    emit = 1'b0;
    res  = '{block_number: idx_r, last: 1'b1, status: STATUS_OK, free_blocks: free_cnt_r};
    case (state_r)
      S_CHECK: begin
        if (no_space && out_free) begin
          emit             = 1'b1;
          res.block_number = '0;
          res.status       = STATUS_NO_SPACE;
        end
      end
      S_SCAN: begin
        if (!cur_taken && out_free) begin
          emit     = 1'b1;
          res.last = (rem_r == CNT_W'(1));
        end
      end
      S_FREE: begin
        if (out_free) begin
          emit = 1'b1;
          if (!in_area) begin
            res.status = STATUS_RANGE;
          end else if (cur_taken) begin
            res.free_blocks = free_cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, map and free count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      map_r      <= '0;
      free_cnt_r <= CNT_W'(NUM_BLOCKS);
    end else if (recount_req) begin
      state_r <= S_RECOUNT;
      idx_r   <= '0;
      acc_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_item.mode)
              MODE_ALLOC_BYTES: state_r <= S_DIV_WAIT;
              MODE_ALLOC_ONE: begin
                needed_r <= NEED_W'(1);
                state_r  <= S_CHECK;
              end
              MODE_FREE: begin
                idx_r   <= in_item.block_number_in;
                state_r <= S_FREE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RECOUNT: begin
          // Count free blocks of the area one map bit per cycle.
          if (idx_r == BLK_W'(NUM_BLOCKS - 1)) begin
            free_cnt_r <= acc_r + acc_inc;
            state_r    <= S_IDLE;
          end else begin
            acc_r <= acc_r + acc_inc;
            idx_r <= idx_r + BLK_W'(1);
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            needed_r <= NEED_W'(div_quo) + NEED_W'(1);
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (no_space) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else begin
            free_cnt_r <= free_cnt_r - needed_r[CNT_W-1:0];
            rem_r      <= needed_r[CNT_W-1:0];
            idx_r      <= '0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // First fit: claim each free block met until enough are taken.
          if (!cur_taken) begin
            if (out_free) begin
              map_r[idx_r] <= 1'b1;
              rem_r        <= rem_r - CNT_W'(1);
              idx_r        <= idx_r + BLK_W'(1);
              if (rem_r == CNT_W'(1)) begin
                state_r <= S_IDLE;
              end
            end
          end else begin
            idx_r <= idx_r + BLK_W'(1);
          end
        end
        S_FREE: begin
          if (out_free) begin
            if (in_area && cur_taken) begin
              map_r[idx_r] <= 1'b0;
              free_cnt_r   <= free_cnt_r + CNT_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a one-bit-per-block occupancy map of 64 blocks.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake             Moves
//   in_       input       in_valid/in_ready     request item (mode, size, block)
//   out_      output      out_valid/out_ready   result item per claimed block, free or failure
//   cfg_      input       cfg_valid/cfg_ready   register index and write data
//
// A size allocation passes through the divider, a check state and a scan state
// that walks the map bits in order; a one-block allocation skips the divider.
// A free goes straight to the free state. Writing blocks_in_use starts a recount
// pass over the map, during which no item is taken.
// Reset clears the map and sets the free count to 64; there is no clearing pass.
// A stalled output holds the scan in place; the sequencer resumes when the
// output register empties.
module bitmap_block_allocator import bbal_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  cfg_t      cfg_r;
  logic      recount_req;
  logic      out_free;
  logic      emit;
  out_item_t res;

  assign cfg_ready   = 1'b1;
  assign recount_req = cfg_valid && (cfg_index == CFG_BLOCKS_IN_USE);
  assign out_free    = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_block <= BPB_RESET;
      cfg_r.blocks_in_use   <= BIU_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BYTES_PER_BLOCK: cfg_r.bytes_per_block <= cfg_data[BPB_W-1:0];
        CFG_BLOCKS_IN_USE:   cfg_r.blocks_in_use   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bbal_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .recount_req (recount_req),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_data),
    .out_free    (out_free),
    .emit        (emit),
    .res         (res)
  );

  // Output register between the sequencer and the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/bbal_checker.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator port checker
// Assertions on the allocator ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_assert.svh"

module bbal_checker import bbal_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_item_t             out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // A stalled result item holds its value.
  `BBAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // A request that does work keeps the block busy in the following cycle.
  `BBAL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready && (in_data.mode != MODE_UNUSED), !in_ready)

  // A failing result is always the only and final one of its request.
  `BBAL_ASSERT_NOW(a_fail_is_last, clk, rst_n, out_valid && (out_data.status != STATUS_OK), out_data.last)

  // The free count never exceeds the map size.
  `BBAL_ASSERT_NOW(a_free_bound, clk, rst_n, out_valid, out_data.free_blocks <= CNT_W'(NUM_BLOCKS))

endmodule

bind bitmap_block_allocator bbal_checker u_bbal_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocation, release and unused requests into the allocator, keeps a
// copy of the occupancy map and free count, and checks every result item in
// order against that copy. Covers the register settings and their extremes,
// a long output stall that backs the block up, and random traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import bbal_pkg::*;

  localparam int TAIL_CYCLES  = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int IDLE_PERCENT = 24;
  localparam int MAX_BYTES    = 4194303;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the allocator state and its registers.
  logic [NUM_BLOCKS-1:0] taken_map;
  int                    free_left;
  logic [BPB_W-1:0]      block_bytes;
  logic [CNT_W-1:0]      area_blocks;

  out_item_t results_due[$];
  int        errors = 0;
  bit        calm = 1'b0;
  int        hold_requests = 0;
  int        holds_served = 0;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  bitmap_block_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Managed area, clipped to the size of the map.
  function automatic int managed_blocks();
    return (area_blocks > NUM_BLOCKS) ? NUM_BLOCKS : int'(area_blocks);
  endfunction

  function automatic void recount_free();
    free_left = 0;
    for (int i = 0; i < managed_blocks(); i++) begin
      if (!taken_map[i]) free_left++;
    end
  endfunction

  function automatic void queue_result(input int blk, input bit fin, input logic [1:0] st);
    out_item_t r;
    r.block_number = blk[BLK_W-1:0];
    r.last         = fin;
    r.status       = st;
    r.free_blocks  = free_left[CNT_W-1:0];
    results_due.push_back(r);
  endfunction

  // First-fit claim of a number of blocks, or a single no-space result.
  function automatic void claim_blocks(input int needed);
    int got;
    got = 0;
    if (needed > free_left) begin
      queue_result(0, 1'b1, STATUS_NO_SPACE);
      return;
    end
    free_left -= needed;
    for (int i = 0; i < managed_blocks() && got < needed; i++) begin
      if (!taken_map[i]) begin
        taken_map[i] = 1'b1;
        got++;
        queue_result(i, got == needed, STATUS_OK);
      end
    end
  endfunction

  // Works out the result items that one accepted request causes.
  function automatic void predict_allocation(input in_item_t req);
    int divisor;
    int blk;
    divisor = (block_bytes == 0) ? 1 : int'(block_bytes);
    blk     = int'(req.block_number_in);
    case (req.mode)
      MODE_ALLOC_BYTES: claim_blocks(int'(req.byte_count) / divisor + 1);
      MODE_ALLOC_ONE:   claim_blocks(1);
      MODE_FREE: begin
        if (blk >= managed_blocks()) begin
          queue_result(blk, 1'b1, STATUS_RANGE);
        end else begin
          if (taken_map[blk]) begin
            taken_map[blk] = 1'b0;
            free_left++;
          end
          queue_result(blk, 1'b1, STATUS_OK);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t make_req(input logic [1:0] m, input int bytes, input int blk);
    in_item_t r;
    r.mode            = m;
    r.byte_count      = bytes[BYTES_W-1:0];
    r.block_number_in = blk[BLK_W-1:0];
    return r;
  endfunction

  // Random request: mostly sizes of a few blocks, frees that mostly hit a
  // taken block, and a little noise in the form of huge sizes and unused modes.
  function automatic in_item_t random_request();
    in_item_t r;
    int pick;
    int eff;
    int start;
    pick  = $urandom_range(99);
    eff   = (block_bytes == 0) ? 1 : int'(block_bytes);
    r     = make_req(MODE_ALLOC_ONE, $urandom, $urandom);
    if (pick < 35) begin
      r.mode = MODE_ALLOC_BYTES;
      if ($urandom_range(9) == 0) r.byte_count = BYTES_W'($urandom_range(MAX_BYTES, 0));
      else r.byte_count = BYTES_W'($urandom_range(eff * 3, 0));
    end else if (pick < 55) begin
      r.mode = MODE_ALLOC_ONE;
    end else if (pick < 95) begin
      r.mode = MODE_FREE;
      if ($urandom_range(1) == 1 && taken_map != '0) begin
        start = $urandom_range(NUM_BLOCKS - 1);
        for (int k = 0; k < NUM_BLOCKS; k++) begin
          if (taken_map[(start + k) % NUM_BLOCKS]) begin
            r.block_number_in = BLK_W'((start + k) % NUM_BLOCKS);
            break;
          end
        end
      end
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  // Offers one item, with random gaps first, and waits for its acceptance.
  task automatic send_item(input in_item_t req);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_allocation(req);
  endtask

  // Stops offering, waits for every outstanding result, then lets the block
  // finish any work that causes no result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_BYTES_PER_BLOCK) begin
      block_bytes = val;
    end else begin
      area_blocks = val[CNT_W-1:0];
      recount_free();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Size extremes, exact fit, no space, holes and release cases after reset.
  task automatic test_file_sizes();
    send_item(make_req(MODE_ALLOC_BYTES, 0, 63));
    send_item(make_req(MODE_ALLOC_BYTES, 1023, 0));
    send_item(make_req(MODE_ALLOC_BYTES, 1024, 0));
    send_item(make_req(MODE_ALLOC_ONE, 0, 0));
    send_item(make_req(MODE_ALLOC_BYTES, MAX_BYTES, 0));
    send_item(make_req(MODE_FREE, 0, 2));
    send_item(make_req(MODE_FREE, MAX_BYTES, 2));
    send_item(make_req(MODE_ALLOC_ONE, MAX_BYTES, 63));
    send_item(make_req(MODE_FREE, 0, 63));
    send_item(make_req(MODE_ALLOC_BYTES, 58 * 1024, 0));
    send_item(make_req(MODE_ALLOC_ONE, 0, 0));
    send_item(make_req(MODE_FREE, 0, 0));
    send_item(make_req(MODE_ALLOC_BYTES, 0, 0));
  endtask

  // The unused mode must give no result at all.
  task automatic test_unused_mode();
    send_item(make_req(MODE_UNUSED, MAX_BYTES, 63));
    send_item(make_req(MODE_UNUSED, 0, 0));
  endtask

  // Area resizing, an empty area, an oversized area and block size extremes.
  task automatic test_area_settings();
    write_register(CFG_BLOCKS_IN_USE, 16'd10);
    send_item(make_req(MODE_FREE, 0, 12));
    send_item(make_req(MODE_FREE, 0, 5));
    send_item(make_req(MODE_ALLOC_ONE, 0, 0));
    write_register(CFG_BLOCKS_IN_USE, 16'd0);
    send_item(make_req(MODE_ALLOC_BYTES, 0, 0));
    send_item(make_req(MODE_FREE, 0, 0));
    write_register(CFG_BLOCKS_IN_USE, 16'd127);
    send_item(make_req(MODE_FREE, 0, 63));
    send_item(make_req(MODE_ALLOC_ONE, 0, 0));
    write_register(CFG_BYTES_PER_BLOCK, 16'd0);
    send_item(make_req(MODE_FREE, 0, 7));
    send_item(make_req(MODE_FREE, 0, 9));
    send_item(make_req(MODE_ALLOC_BYTES, 1, 0));
    write_register(CFG_BYTES_PER_BLOCK, 16'hFFFF);
    send_item(make_req(MODE_ALLOC_BYTES, MAX_BYTES, 0));
    write_register(CFG_BLOCKS_IN_USE, 16'd1);
    send_item(make_req(MODE_FREE, 0, 1));
    send_item(make_req(MODE_FREE, 0, 0));
    send_item(make_req(MODE_ALLOC_ONE, 0, 0));
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      send_item(random_request());
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block backs up and stalls its input.
  task automatic test_output_backpressure();
    settle();
    hold_requests++;
    calm = 1'b1;
    for (int k = 0; k < 8; k++) begin
      send_item(make_req(MODE_FREE, 0, k));
      send_item(make_req(MODE_ALLOC_ONE, 0, 0));
    end
    calm = 1'b0;
  endtask

  // Receiver: random stalls, a long hold on request, or always ready.
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      stall_left   = HOLD_CYCLES;
      holds_served = hold_requests;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Each result item is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual block %0d last %0b status %0d free %0d",
                 $time, out_data.block_number, out_data.last, out_data.status,
                 out_data.free_blocks);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("block_number", want.block_number, out_data.block_number);
        check_field("last", want.last, out_data.last);
        check_field("status", want.status, out_data.status);
        check_field("free_blocks", want.free_blocks, out_data.free_blocks);
      end
    end
  end

  // Watchdog on cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    taken_map   = '0;
    block_bytes = BPB_RESET;
    area_blocks = BIU_RESET;
    recount_free();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_file_sizes();
    test_unused_mode();
    test_area_settings();

    // Default settings, starting with a stretch of no idling and pausing
    // halfway until everything has come back.
    write_register(CFG_BYTES_PER_BLOCK, BPB_RESET);
    write_register(CFG_BLOCKS_IN_USE, 16'd64);
    calm = 1'b1;
    test_random_traffic(10);
    calm = 1'b0;
    settle();
    test_random_traffic(15);

    // Smallest block size with a random area.
    write_register(CFG_BYTES_PER_BLOCK, 16'd1);
    write_register(CFG_BLOCKS_IN_USE, 16'($urandom_range(64, 20)));
    test_random_traffic(20);

    // Largest block size over an oversized area.
    write_register(CFG_BYTES_PER_BLOCK, 16'hFFFF);
    write_register(CFG_BLOCKS_IN_USE, 16'd100);
    test_random_traffic(20);

    test_output_backpressure();

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
